// ----- sv/tlca_pkg.sv -----
package tlca_pkg;

   // Node and depth fields are fixed at ten bits.
   localparam int NODE_W = 10;
   localparam int DEPTH_W = 10;

   // Default table depth.
   localparam int MAX_NODES_DEFAULT = 1024;

   // A walk that has not met after this many steps stops.
   localparam int WALK_LIMIT = 2048;
   localparam int STEP_W = $clog2(WALK_LIMIT + 1);

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [STEP_W-1:0] step_type;

   // Operation codes of an input item.
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   // Table write request.
   typedef struct packed {
      logic en;
      node_type node;
      node_type parent;
      depth_type depth;
   } tbl_wr_type;

   // Table read request, two nodes per cycle.
   typedef struct packed {
      node_type node_a;
      node_type node_b;
   } tbl_rd_type;

   // Table read data, registered: it arrives in the cycle after the request.
   typedef struct packed {
      node_type parent_a;
      node_type parent_b;
      depth_type depth_a;
      depth_type depth_b;
   } tbl_data_type;

   // One table entry.
   typedef struct packed {
      node_type parent;
      depth_type depth;
   } entry_type;

endpackage

// ----- sv/tree_lca_parent_walk_unit.sv -----
// Lowest common ancestor by an upward parent walk over a parent/depth table memory.
// A write transfer leaves busy low; the next item may follow at once.
// A query holds busy while it walks and strobes its result in its last busy cycle;
// its walk steps never exceed 2048. One step per cycle, set by the
// registered table read feeding the next read address. The receiver cannot stall.
// Synchronous reset returns the controller to idle; table contents are kept, not cleared.
module tree_lca_parent_walk_unit #(
   parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_op,
   input  tlca_pkg::node_type  req_node_index,
   input  tlca_pkg::node_type  req_parent_index,
   input  tlca_pkg::depth_type req_node_depth,
   input  tlca_pkg::node_type  req_first_node,
   input  tlca_pkg::node_type  req_second_node,
   output logic                rsp_strobe,
   output tlca_pkg::node_type  rsp_ancestor
);
   import tlca_pkg::*;

   tbl_wr_type   wr;
   tbl_rd_type   rd;
   tbl_data_type data;

   // Walk controller.
   tlca_walk u_walk (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_node_index   (req_node_index),
      .req_parent_index (req_parent_index),
      .req_node_depth   (req_node_depth),
      .req_first_node   (req_first_node),
      .req_second_node  (req_second_node),
      .rsp_strobe       (rsp_strobe),
      .rsp_ancestor     (rsp_ancestor),
      .wr               (wr),
      .rd               (rd),
      .data             (data)
   );

   // Parent and depth table.
   tlca_table #(
      .MAX_NODES (MAX_NODES)
   ) u_table (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .data  (data)
   );

endmodule

// ----- sv/tlca_table.sv -----
module tlca_table #(
   parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEFAULT
) (
   input  logic                   clock,
   input  tlca_pkg::tbl_wr_type   wr,
   input  tlca_pkg::tbl_rd_type   rd,
   output tlca_pkg::tbl_data_type data
);
   import tlca_pkg::*;

   localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

   entry_type mem [MAX_NODES];

   entry_type entry_a_ff;
   entry_type entry_b_ff;
   node_type  node_a_ff;
   node_type  node_b_ff;
   logic      ok_a_ff;
   logic      ok_b_ff;

   logic wr_ok;
   logic ok_a_in;
   logic ok_b_in;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;

   // Nodes beyond the table are roots: no write, no read.
   always_comb begin
      wr_ok = 32'(wr.node) < 32'(MAX_NODES);
      ok_a_in = 32'(rd.node_a) < 32'(MAX_NODES);
      ok_b_in = 32'(rd.node_b) < 32'(MAX_NODES);
      wr_addr = ADDR_W'(wr.node);
      rd_addr_a = ADDR_W'(rd.node_a);
      rd_addr_b = ADDR_W'(rd.node_b);
   end

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr.en && wr_ok) begin
         mem[wr_addr] <= '{parent: wr.parent, depth: wr.depth};
      end
   end

   // Two registered read ports, with the nodes kept for the root case.
   always_ff @(posedge clock) begin
      entry_a_ff <= ok_a_in ? mem[rd_addr_a] : '0;
      entry_b_ff <= ok_b_in ? mem[rd_addr_b] : '0;
      node_a_ff <= rd.node_a;
      node_b_ff <= rd.node_b;
      ok_a_ff <= ok_a_in;
      ok_b_ff <= ok_b_in;
   end

   // A node outside the table is its own parent at depth zero.
   always_comb begin
      data.parent_a = ok_a_ff ? entry_a_ff.parent : node_a_ff;
      data.parent_b = ok_b_ff ? entry_b_ff.parent : node_b_ff;
      data.depth_a = ok_a_ff ? entry_a_ff.depth : '0;
      data.depth_b = ok_b_ff ? entry_b_ff.depth : '0;
   end

endmodule

// ----- sv/tlca_walk.sv -----
module tlca_walk (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_op,
   input  tlca_pkg::node_type     req_node_index,
   input  tlca_pkg::node_type     req_parent_index,
   input  tlca_pkg::depth_type    req_node_depth,
   input  tlca_pkg::node_type     req_first_node,
   input  tlca_pkg::node_type     req_second_node,
   output logic                   rsp_strobe,
   output tlca_pkg::node_type     rsp_ancestor,
   output tlca_pkg::tbl_wr_type   wr,
   output tlca_pkg::tbl_rd_type   rd,
   input  tlca_pkg::tbl_data_type data
);
   import tlca_pkg::*;

   state_type state_ff;
   state_type state_in;
   node_type  a_ff;
   node_type  a_in;
   node_type  b_ff;
   node_type  b_in;
   step_type  step_ff;
   step_type  step_in;

   logic     accept;
   logic     done;
   node_type next_a;
   node_type next_b;

   // State and walk registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      step_ff <= step_in;
   end

   // One walk step: the deeper node climbs, at equal depth both climb.
   always_comb begin
      if (data.depth_a < data.depth_b) begin
         next_a = a_ff;
         next_b = data.parent_b;
      end else if (data.depth_a > data.depth_b) begin
         next_a = data.parent_a;
         next_b = b_ff;
      end else begin
         next_a = data.parent_a;
         next_b = data.parent_b;
      end
   end

   // Next state, table requests and the result strobe.
   always_comb begin
      accept = start && (state_ff == ST_IDLE);
      done = (a_ff == b_ff) || (step_ff == STEP_W'(WALK_LIMIT));
      state_in = state_ff;
      a_in = a_ff;
      b_in = b_ff;
      step_in = step_ff;
      rsp_strobe = 1'b0;
      wr.en = accept && (req_op == OP_WRITE);
      wr.node = req_node_index;
      wr.parent = req_parent_index;
      wr.depth = req_node_depth;
      rd.node_a = req_first_node;
      rd.node_b = req_second_node;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_QUERY)) begin
               a_in = req_first_node;
               b_in = req_second_node;
               step_in = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            rd.node_a = next_a;
            rd.node_b = next_b;
            if (done) begin
               rsp_strobe = 1'b1;
               state_in = ST_IDLE;
            end else begin
               a_in = next_a;
               b_in = next_b;
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_ancestor = b_ff;

endmodule

// ----- bench/tree_lca_parent_walk_unit_tb.sv -----
module tree_lca_parent_walk_unit_tb;
   import tlca_pkg::*;

   localparam int ITEM_TARGET = 1650;
   localparam int QUIET_TAIL = 150;
   localparam int STALL_LIMIT = 12000;
   localparam int DRAIN_CYCLES = 2100;
   localparam int TABLE_SIZE = MAX_NODES_DEFAULT;
   localparam int DEEP_ROOM = 520;

   // One input item with every field the request channel carries.
   typedef struct {
      op_type    op;
      node_type  node;
      node_type  parent;
      depth_type depth;
      node_type  first_node;
      node_type  second_node;
   } lca_item_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   logic      req_op = 1'b0;
   node_type  req_node_index = '0;
   node_type  req_parent_index = '0;
   depth_type req_node_depth = '0;
   node_type  req_first_node = '0;
   node_type  req_second_node = '0;
   logic      rsp_strobe;
   node_type  rsp_ancestor;

   // Items waiting to be driven and ancestors waiting to come back.
   lca_item_type pending[$];
   node_type  expected_ancestors[$];

   // Tables as the block will hold them once each transfer has happened.
   node_type  model_parent[0:TABLE_SIZE-1];
   depth_type model_depth[0:TABLE_SIZE-1];

   // Tables as they will stand when the queued items have been applied; used
   // only to keep queries away from entries that were never written.
   node_type  plan_parent[0:TABLE_SIZE-1];
   depth_type plan_depth[0:TABLE_SIZE-1];
   bit        plan_written[0:TABLE_SIZE-1];

   lca_item_type cur_item;
   int        hold_off = 0;
   int        calm_left = 0;
   int        stall_cycles = 0;
   int        error_count = 0;
   node_type  want_ancestor;

   tree_lca_parent_walk_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_node_index   (req_node_index),
      .req_parent_index (req_parent_index),
      .req_node_depth   (req_node_depth),
      .req_first_node   (req_first_node),
      .req_second_node  (req_second_node),
      .rsp_strobe       (rsp_strobe),
      .rsp_ancestor     (rsp_ancestor)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Upward walk over the tables: the deeper node climbs, equal depths both climb.
   function automatic node_type lca_of(node_type a, node_type b);
      node_type x;
      node_type y;
      int       steps;
      x = a;
      y = b;
      steps = 0;
      while (x != y && steps < WALK_LIMIT) begin
         if (model_depth[x] < model_depth[y]) begin
            y = model_parent[y];
         end else if (model_depth[x] > model_depth[y]) begin
            x = model_parent[x];
         end else begin
            x = model_parent[x];
            y = model_parent[y];
         end
         steps++;
      end
      return y;
   endfunction

   // True when every node the walk visits holds written entries.
   function automatic bit walk_stays_written(node_type a, node_type b);
      node_type x;
      node_type y;
      int       steps;
      x = a;
      y = b;
      steps = 0;
      if (!plan_written[x] || !plan_written[y]) return 1'b0;
      while (x != y && steps < WALK_LIMIT) begin
         if (plan_depth[x] < plan_depth[y]) begin
            y = plan_parent[y];
         end else if (plan_depth[x] > plan_depth[y]) begin
            x = plan_parent[x];
         end else begin
            x = plan_parent[x];
            y = plan_parent[y];
         end
         steps++;
         if (!plan_written[x] || !plan_written[y]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Queue a table write; the query fields carry random filler.
   task automatic push_write(input node_type n, input node_type p, input depth_type d);
      lca_item_type it;
      it.op = OP_WRITE;
      it.node = n;
      it.parent = p;
      it.depth = d;
      it.first_node = node_type'($urandom_range(0, TABLE_SIZE - 1));
      it.second_node = node_type'($urandom_range(0, TABLE_SIZE - 1));
      pending.push_back(it);
      plan_parent[n] = p;
      plan_depth[n] = d;
      plan_written[n] = 1'b1;
   endtask

   // Queue a query unless its walk would touch an unwritten entry.
   task automatic push_query(input node_type a, input node_type b);
      lca_item_type it;
      if (walk_stays_written(a, b)) begin
         it.op = OP_QUERY;
         it.node = node_type'($urandom_range(0, TABLE_SIZE - 1));
         it.parent = node_type'($urandom_range(0, TABLE_SIZE - 1));
         it.depth = depth_type'($urandom_range(0, TABLE_SIZE - 1));
         it.first_node = a;
         it.second_node = b;
         pending.push_back(it);
      end
   endtask

   // Update the tables or predict the ancestor for one accepted transfer.
   task automatic apply_transfer(input lca_item_type it);
      if (it.op == OP_WRITE) begin
         model_parent[it.node] = it.parent;
         model_depth[it.node] = it.depth;
      end else begin
         expected_ancestors.push_back(lca_of(it.first_node, it.second_node));
      end
   endtask

   // Driver: present queued items, hold them while busy, insert idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         hold_off <= 0;
      end else begin
         if (start && !busy) apply_transfer(cur_item);
         if (start && busy) begin
            // The current item stays on the ports until the transfer.
         end else if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            start <= 1'b0;
         end else if (pending.size() != 0) begin
            cur_item = pending.pop_front();
            req_op <= cur_item.op;
            req_node_index <= cur_item.node;
            req_parent_index <= cur_item.parent;
            req_node_depth <= cur_item.depth;
            req_first_node <= cur_item.first_node;
            req_second_node <= cur_item.second_node;
            start <= 1'b1;
            // Idle bursts after some items, with calm stretches and a quiet tail.
            if (calm_left != 0) begin
               calm_left <= calm_left - 1;
            end else if (pending.size() > QUIET_TAIL) begin
               if ($urandom_range(0, 19) == 0) begin
                  calm_left <= $urandom_range(10, 60);
               end else if ($urandom_range(0, 3) == 0) begin
                  hold_off <= $urandom_range(1, 19);
               end
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare each strobed result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_ancestors.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual ancestor %0d",
                     $time, rsp_ancestor);
            error_count++;
         end else begin
            want_ancestor = expected_ancestors.pop_front();
            if (rsp_ancestor !== want_ancestor) begin
               $display("%0t: ancestor mismatch, expected %0d, actual %0d",
                        $time, want_ancestor, rsp_ancestor);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long without any transfer on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus generation, reset and end of run.
   initial begin
      node_type  members[0:299];
      int        tree_depth[0:299];
      bit        taken[0:TABLE_SIZE-1];
      node_type  qa;
      node_type  qb;
      int        tree_size;
      int        nq;
      int        i;
      int        j;
      int        r;
      bit        deep;

      for (i = 0; i < TABLE_SIZE; i++) begin
         model_parent[i] = '0;
         model_depth[i] = '0;
         plan_written[i] = 1'b0;
      end

      // Directed part: a small tree rooted at the top index.
      push_write(10'd1023, 10'd1023, 10'd0);
      push_write(10'd0, 10'd1023, 10'd1);
      push_write(10'd512, 10'd0, 10'd2);
      push_write(10'd341, 10'd0, 10'd2);
      push_write(10'd682, 10'd512, 10'd3);
      push_query(10'd682, 10'd341);
      push_query(10'd341, 10'd682);
      push_query(10'd1023, 10'd1023);
      push_query(10'd682, 10'd1023);
      push_query(10'd0, 10'd682);
      push_query(10'd682, 10'd682);
      // A second root never meets the first, so the walk runs to its limit.
      push_write(10'd5, 10'd5, 10'd0);
      push_query(10'd5, 10'd682);
      // Two nodes that are each other's parent form a cycle.
      push_write(10'd6, 10'd7, 10'd1);
      push_write(10'd7, 10'd6, 10'd1);
      push_query(10'd6, 10'd7);
      // A depth at the top of its range that does not fit the tree.
      push_write(10'd1, 10'd1023, 10'd1023);
      push_query(10'd1, 10'd0);
      push_query(10'd0, 10'd1);
      // Rewriting an entry moves a subtree.
      push_write(10'd512, 10'd341, 10'd3);
      push_query(10'd682, 10'd341);
      push_query(10'd682, 10'd0);

      // Random part: build a fresh tree, then query pairs from it.
      while (pending.size() < ITEM_TARGET) begin
         // Deep trees only while there is room for one before the item count.
         deep = ($urandom_range(0, 19) == 0) && (pending.size() + DEEP_ROOM < ITEM_TARGET);
         tree_size = deep ? $urandom_range(60, 250) : $urandom_range(2, 40);
         for (i = 0; i < TABLE_SIZE; i++) taken[i] = 1'b0;
         for (i = 0; i < tree_size; i++) begin
            do members[i] = node_type'($urandom_range(0, TABLE_SIZE - 1));
            while (taken[members[i]]);
            taken[members[i]] = 1'b1;
         end
         push_write(members[0], members[0], '0);
         tree_depth[0] = 0;
         for (i = 1; i < tree_size; i++) begin
            // Deep trees hang each node near the last one to make long chains.
            j = deep ? $urandom_range(i > 3 ? i - 3 : 0, i - 1) : $urandom_range(0, i - 1);
            tree_depth[i] = tree_depth[j] + 1;
            push_write(members[i], members[j], depth_type'(tree_depth[i]));
            // Now and then a small tree gets a corrupted entry.
            if (!deep && $urandom_range(0, 19) == 0) begin
               push_write(members[$urandom_range(0, i)], members[$urandom_range(0, i)],
                          depth_type'($urandom_range(0, TABLE_SIZE - 1)));
            end
         end
         nq = $urandom_range(tree_size / 2 + 1, tree_size + 3);
         for (i = 0; i < nq; i++) begin
            r = $urandom_range(0, 19);
            qa = members[$urandom_range(0, tree_size - 1)];
            qb = members[$urandom_range(0, tree_size - 1)];
            if (r == 0) begin
               qb = qa;
            end else if (r == 1) begin
               qa = node_type'($urandom_range(0, TABLE_SIZE - 1));
               qb = node_type'($urandom_range(0, TABLE_SIZE - 1));
            end else if (r == 2) begin
               qb = node_type'($urandom_range(0, TABLE_SIZE - 1));
            end
            push_query(qa, qb);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to transfer, every result to arrive, then drain.
      while (pending.size() != 0 || start) @(posedge clock);
      while (expected_ancestors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_ancestors.size() != 0) begin
         $display("%0t: %0d expected ancestors never arrived",
                  $time, expected_ancestors.size());
      end
      if (error_count == 0 && expected_ancestors.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/tlca_pkg.sv
sv/tlca_table.sv
sv/tlca_walk.sv
sv/tree_lca_parent_walk_unit.sv
bench/tree_lca_parent_walk_unit_tb.sv
